// ===== rtl/pstrq_pkg.sv =====
// ----------------------------------------------------------------------------
// pstrq_pkg: shared types and codes for the process slot table
// Slot state, command, status codes, sequencer states and table write strobes.
// ----------------------------------------------------------------------------
package pstrq_pkg;

    // slot states
    localparam logic [2:0] ST_FREE     = 3'd0;
    localparam logic [2:0] ST_RUNNABLE = 3'd1;
    localparam logic [2:0] ST_RUNNING  = 3'd2;
    localparam logic [2:0] ST_WAITING  = 3'd3;
    localparam logic [2:0] ST_EXITED   = 3'd4;
    localparam logic [2:0] ST_RETIRED  = 3'd5;

    // commands
    localparam logic [3:0] ACT_SPAWN    = 4'd0;
    localparam logic [3:0] ACT_DISPATCH = 4'd1;
    localparam logic [3:0] ACT_YIELD    = 4'd2;
    localparam logic [3:0] ACT_WAIT     = 4'd3;
    localparam logic [3:0] ACT_WAKE     = 4'd4;
    localparam logic [3:0] ACT_REQUEUE  = 4'd5;
    localparam logic [3:0] ACT_EXIT     = 4'd6;
    localparam logic [3:0] ACT_ALIVE    = 4'd7;
    localparam logic [3:0] ACT_RUNHEAD  = 4'd8;

    // result status
    localparam logic [1:0] RS_OK       = 2'd0;
    localparam logic [1:0] RS_LIMIT    = 2'd1;
    localparam logic [1:0] RS_BADPID   = 2'd2;
    localparam logic [1:0] RS_BADSTATE = 2'd3;

    localparam logic [6:0] MAX_LIVE_RST = 7'd64;

    typedef enum logic [7:0] {
        S_CLR     = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_SCAN_RD = 8'b0000_0100,
        S_SCAN_CK = 8'b0000_1000,
        S_CK      = 8'b0001_0000,
        S_APP1    = 8'b0010_0000,
        S_APP2    = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } t_fsm;

    // write strobes of the three table memories
    typedef struct packed {
        logic sg;
        logic nx;
        logic pv;
    } t_tbl_we;

endpackage

// ===== rtl/process_slot_table_run_queue_top.sv =====
// ----------------------------------------------------------------------------
// process_slot_table_run_queue_top: process slot table with FIFO run queue
// Sequencer over the slot table memories for spawn, dispatch, yield, wait,
// wake, requeue, exit, alive and run-head requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s-side stream (i_s_tvalid/o_s_tready/i_s_tdata),
//   one result leaves per request on the m-side stream (o_m_tvalid/
//   i_m_tready/o_m_tdata). max_live is written through i_cfg_we/i_cfg_wdata
//   while no request is in flight.
//   Every request runs through the single table read port and one sequencer:
//     run head, unknown request and a spawn refused at once go straight to
//     the final step; alive, wait, dispatch and exit check the slot first;
//     yield, wake and requeue, when accepted, then append to the queue (a
//     second link step when the queue is not empty); spawn reads and checks
//     each slot from the free hint until it finds one, then appends it.
//   The block takes one request at a time; o_s_tready is high only when idle.
//   A finished result sits in the output register; the next request is taken
//   while it waits, and that request holds in its last step until the
//   receiver takes the earlier result.
//   After reset the slot table is cleared one slot a cycle, during which
//   o_s_tready stays low; config writes are taken meanwhile.
// ----------------------------------------------------------------------------
module process_slot_table_run_queue_top #(
    parameter int NSLOT   = 64,
    parameter int GEN_MAX = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,  // max_live
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,    // action[3:0], pid_slot[9:4], pid_generation[17:10]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata     // status[1:0], out_slot[7:2], out_generation[15:8], flag[16]
);

    localparam int SW = $clog2(NSLOT);
    localparam int GW = $clog2(GEN_MAX + 1);
    localparam int LW = SW + 1;
    localparam int HW = SW + 1;
    localparam int PW = (SW > 6) ? SW : 6;
    localparam int EW = (GW > 8) ? GW : 8;
    localparam int CW = (HW > 7) ? HW : 7;
    localparam logic [LW-1:0] LINK_NONE = {1'b1, {SW{1'b0}}};

    // request fields
    logic [3:0]    in_act;
    logic [PW-1:0] in_slot_w;
    logic [SW-1:0] in_slot;
    logic          in_slot_ok;
    logic [7:0]    in_gen;

    assign in_act     = i_s_tdata[3:0];
    assign in_slot_w  = PW'(i_s_tdata[9:4]);
    assign in_slot    = in_slot_w[SW-1:0];
    assign in_slot_ok = 32'(in_slot_w) < 32'(NSLOT);
    assign in_gen     = i_s_tdata[17:10];

    pstrq_pkg::t_fsm r_fsm, n_fsm;
    logic [3:0]    r_act, n_act;
    logic [SW-1:0] r_s, n_s;
    logic          r_s_ok, n_s_ok;
    logic [7:0]    r_g, n_g;
    logic [HW-1:0] r_k, n_k;
    logic [HW-1:0] r_hint, n_hint;
    logic [HW-1:0] r_live, n_live;
    logic [LW-1:0] r_head, n_head;
    logic [LW-1:0] r_tail, n_tail;
    logic [6:0]    r_max_live;
    logic [1:0]    r_status, n_status;
    logic [5:0]    r_oslot, n_oslot;
    logic [7:0]    r_ogen, n_ogen;
    logic          r_flag, n_flag;
    logic          r_m_valid;
    logic [23:0]   r_m_data;

    // table ports
    pstrq_pkg::t_tbl_we we;
    logic [SW-1:0] sg_waddr, nx_waddr, pv_waddr, raddr;
    logic [GW+2:0] sg_wdata, sg_rdata;
    logic [LW-1:0] nx_wdata, pv_wdata, nx_rdata, pv_rdata;

    pstrq_table #(.SW(SW), .GW(GW)) u_table (
        .i_clk      (i_clk),
        .i_we       (we),
        .i_sg_waddr (sg_waddr),
        .i_sg_wdata (sg_wdata),
        .i_nx_waddr (nx_waddr),
        .i_nx_wdata (nx_wdata),
        .i_pv_waddr (pv_waddr),
        .i_pv_wdata (pv_wdata),
        .i_raddr    (raddr),
        .o_sg_rdata (sg_rdata),
        .o_nx_rdata (nx_rdata),
        .o_pv_rdata (pv_rdata)
    );

    logic [2:0]    rd_st;
    logic [GW-1:0] rd_gen;
    logic          pid_ok;
    logic          gen_at_max;
    logic [GW:0]   ng_w;
    logic [GW-1:0] ng;
    logic          accept;
    logic          out_free;

    assign rd_st      = sg_rdata[GW+2:GW];
    assign rd_gen     = sg_rdata[GW-1:0];
    assign pid_ok     = r_s_ok && (EW'(rd_gen) == EW'(r_g)) &&
                        (rd_st == pstrq_pkg::ST_RUNNABLE || rd_st == pstrq_pkg::ST_RUNNING ||
                         rd_st == pstrq_pkg::ST_WAITING);
    assign gen_at_max = 32'(rd_gen) == 32'(GEN_MAX);
    assign ng_w       = (GW + 1)'(rd_gen) + (GW + 1)'(1);
    assign ng         = (32'(ng_w) > 32'(GEN_MAX)) ? GW'(1) : ng_w[GW-1:0];
    assign o_s_tready = (r_fsm == pstrq_pkg::S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_m_valid || i_m_tready;

    always_comb begin
        n_fsm    = r_fsm;
        n_act    = r_act;
        n_s      = r_s;
        n_s_ok   = r_s_ok;
        n_g      = r_g;
        n_k      = r_k;
        n_hint   = r_hint;
        n_live   = r_live;
        n_head   = r_head;
        n_tail   = r_tail;
        n_status = r_status;
        n_oslot  = r_oslot;
        n_ogen   = r_ogen;
        n_flag   = r_flag;
        we       = '0;
        sg_waddr = r_s;
        sg_wdata = {rd_st, rd_gen};
        nx_waddr = r_s;
        nx_wdata = LINK_NONE;
        pv_waddr = r_s;
        pv_wdata = r_tail;
        raddr    = r_s;

        case (r_fsm)
            pstrq_pkg::S_CLR: begin
                we.sg    = 1'b1;
                sg_waddr = r_k[SW-1:0];
                sg_wdata = {pstrq_pkg::ST_FREE, {GW{1'b0}}};
                if (r_k == HW'(NSLOT - 1)) begin
                    n_k   = '0;
                    n_fsm = pstrq_pkg::S_IDLE;
                end else begin
                    n_k = r_k + HW'(1);
                end
            end
            pstrq_pkg::S_IDLE: begin
                raddr = in_slot;
                if (accept) begin
                    n_act    = in_act;
                    n_s      = in_slot;
                    n_s_ok   = in_slot_ok;
                    n_g      = in_gen;
                    n_status = pstrq_pkg::RS_OK;
                    n_oslot  = '0;
                    n_ogen   = '0;
                    n_flag   = 1'b0;
                    case (in_act)
                        pstrq_pkg::ACT_SPAWN: begin
                            if (CW'(r_live) >= CW'(r_max_live) ||
                                32'(r_hint) >= 32'(NSLOT)) begin
                                n_status = pstrq_pkg::RS_LIMIT;
                                n_fsm    = pstrq_pkg::S_DONE;
                            end else begin
                                n_k   = r_hint;
                                n_fsm = pstrq_pkg::S_SCAN_RD;
                            end
                        end
                        pstrq_pkg::ACT_DISPATCH, pstrq_pkg::ACT_YIELD, pstrq_pkg::ACT_WAIT,
                        pstrq_pkg::ACT_WAKE, pstrq_pkg::ACT_REQUEUE, pstrq_pkg::ACT_EXIT,
                        pstrq_pkg::ACT_ALIVE: begin
                            n_fsm = pstrq_pkg::S_CK;
                        end
                        pstrq_pkg::ACT_RUNHEAD: begin
                            if (!r_head[SW]) begin
                                n_oslot = 6'(r_head[SW-1:0]);
                                n_flag  = 1'b1;
                            end
                            n_fsm = pstrq_pkg::S_DONE;
                        end
                        default: begin
                            n_fsm = pstrq_pkg::S_DONE;
                        end
                    endcase
                end
            end
            pstrq_pkg::S_SCAN_RD: begin
                raddr = r_k[SW-1:0];
                n_fsm = pstrq_pkg::S_SCAN_CK;
            end
            pstrq_pkg::S_SCAN_CK: begin
                sg_waddr = r_k[SW-1:0];
                if (rd_st == pstrq_pkg::ST_EXITED && gen_at_max) begin
                    // retire for good and keep scanning
                    we.sg    = 1'b1;
                    sg_wdata = {pstrq_pkg::ST_RETIRED, rd_gen};
                end
                if ((rd_st == pstrq_pkg::ST_FREE || rd_st == pstrq_pkg::ST_EXITED) &&
                    !(rd_st == pstrq_pkg::ST_EXITED && gen_at_max)) begin
                    we.sg    = 1'b1;
                    sg_wdata = {pstrq_pkg::ST_RUNNABLE, ng};
                    n_s      = r_k[SW-1:0];
                    n_hint   = r_k + HW'(1);
                    n_live   = r_live + HW'(1);
                    n_oslot  = 6'(r_k);
                    n_ogen   = 8'(EW'(ng));
                    n_fsm    = pstrq_pkg::S_APP1;
                end else if (r_k == HW'(NSLOT - 1)) begin
                    n_status = pstrq_pkg::RS_LIMIT;
                    n_fsm    = pstrq_pkg::S_DONE;
                end else begin
                    n_k   = r_k + HW'(1);
                    n_fsm = pstrq_pkg::S_SCAN_RD;
                end
            end
            pstrq_pkg::S_CK: begin
                n_fsm = pstrq_pkg::S_DONE;
                case (r_act)
                    pstrq_pkg::ACT_DISPATCH: begin
                        if (!pid_ok) begin
                            n_status = pstrq_pkg::RS_BADPID;
                        end else if (rd_st != pstrq_pkg::ST_RUNNABLE) begin
                            n_status = pstrq_pkg::RS_BADSTATE;
                        end else begin
                            we.sg    = 1'b1;
                            sg_wdata = {pstrq_pkg::ST_RUNNING, rd_gen};
                        end
                    end
                    pstrq_pkg::ACT_YIELD, pstrq_pkg::ACT_WAIT: begin
                        if (!pid_ok) begin
                            n_status = pstrq_pkg::RS_BADPID;
                        end else if (rd_st != pstrq_pkg::ST_RUNNING) begin
                            n_status = pstrq_pkg::RS_BADSTATE;
                        end else if (r_act == pstrq_pkg::ACT_YIELD) begin
                            we.sg    = 1'b1;
                            sg_wdata = {pstrq_pkg::ST_RUNNABLE, rd_gen};
                            n_fsm    = pstrq_pkg::S_APP1;
                        end else begin
                            we.sg    = 1'b1;
                            sg_wdata = {pstrq_pkg::ST_WAITING, rd_gen};
                        end
                    end
                    pstrq_pkg::ACT_WAKE: begin
                        if (!r_s_ok) begin
                            n_status = pstrq_pkg::RS_BADPID;
                        end else if (rd_st != pstrq_pkg::ST_WAITING) begin
                            n_status = pstrq_pkg::RS_BADSTATE;
                        end else begin
                            we.sg    = 1'b1;
                            sg_wdata = {pstrq_pkg::ST_RUNNABLE, rd_gen};
                            n_fsm    = pstrq_pkg::S_APP1;
                        end
                    end
                    pstrq_pkg::ACT_REQUEUE: begin
                        if (!r_s_ok) begin
                            n_status = pstrq_pkg::RS_BADPID;
                        end else if (rd_st != pstrq_pkg::ST_RUNNABLE) begin
                            n_status = pstrq_pkg::RS_BADSTATE;
                        end else begin
                            n_fsm = pstrq_pkg::S_APP1;
                        end
                    end
                    pstrq_pkg::ACT_EXIT: begin
                        if (pid_ok) begin
                            we.sg    = 1'b1;
                            sg_wdata = {pstrq_pkg::ST_EXITED, rd_gen};
                            if (HW'(r_s) < r_hint) begin
                                n_hint = HW'(r_s);
                            end
                            if (r_live != '0) begin
                                n_live = r_live - HW'(1);
                            end
                            n_flag = 1'b1;
                        end
                    end
                    pstrq_pkg::ACT_ALIVE: begin
                        n_flag = pid_ok;
                    end
                    default: begin
                    end
                endcase
                // unlink the slot when it leaves the queue or moves to its end
                if (rd_st == pstrq_pkg::ST_RUNNABLE &&
                    ((r_act == pstrq_pkg::ACT_DISPATCH && pid_ok) ||
                     (r_act == pstrq_pkg::ACT_EXIT && pid_ok) ||
                     (r_act == pstrq_pkg::ACT_REQUEUE && r_s_ok))) begin
                    if (pv_rdata[SW]) begin
                        n_head = nx_rdata;
                    end else begin
                        we.nx    = 1'b1;
                        nx_waddr = pv_rdata[SW-1:0];
                        nx_wdata = nx_rdata;
                    end
                    if (nx_rdata[SW]) begin
                        n_tail = pv_rdata;
                    end else begin
                        we.pv    = 1'b1;
                        pv_waddr = nx_rdata[SW-1:0];
                        pv_wdata = pv_rdata;
                    end
                end
            end
            pstrq_pkg::S_APP1: begin
                we.pv    = 1'b1;
                pv_waddr = r_s;
                pv_wdata = r_tail;
                we.nx    = 1'b1;
                if (r_tail[SW]) begin
                    nx_waddr = r_s;
                    nx_wdata = LINK_NONE;
                    n_head   = {1'b0, r_s};
                    n_tail   = {1'b0, r_s};
                    n_fsm    = pstrq_pkg::S_DONE;
                end else begin
                    nx_waddr = r_tail[SW-1:0];
                    nx_wdata = {1'b0, r_s};
                    n_fsm    = pstrq_pkg::S_APP2;
                end
            end
            pstrq_pkg::S_APP2: begin
                we.nx    = 1'b1;
                nx_waddr = r_s;
                nx_wdata = LINK_NONE;
                n_tail   = {1'b0, r_s};
                n_fsm    = pstrq_pkg::S_DONE;
            end
            pstrq_pkg::S_DONE: begin
                // hold until the output register frees up
                if (out_free) begin
                    n_fsm = pstrq_pkg::S_IDLE;
                end
            end
            default: begin
                n_fsm = pstrq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm      <= pstrq_pkg::S_CLR;
            r_k        <= '0;
            r_hint     <= '0;
            r_live     <= '0;
            r_head     <= LINK_NONE;
            r_tail     <= LINK_NONE;
            r_max_live <= pstrq_pkg::MAX_LIVE_RST;
            r_m_valid  <= 1'b0;
        end else begin
            r_fsm  <= n_fsm;
            r_k    <= n_k;
            r_hint <= n_hint;
            r_live <= n_live;
            r_head <= n_head;
            r_tail <= n_tail;
            if (i_cfg_we) begin
                r_max_live <= i_cfg_wdata;
            end
            if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            if (r_fsm == pstrq_pkg::S_DONE && out_free) begin
                r_m_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_s      <= n_s;
        r_s_ok   <= n_s_ok;
        r_g      <= n_g;
        r_status <= n_status;
        r_oslot  <= n_oslot;
        r_ogen   <= n_ogen;
        r_flag   <= n_flag;
        if (r_fsm == pstrq_pkg::S_DONE && out_free) begin
            r_m_data <= {7'd0, r_flag, r_ogen, r_oslot, r_status};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    // queue ends are empty together
    a_head_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head[SW] == r_tail[SW])
        else $error("run queue head and tail disagree on empty");

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_live) <= 32'(NSLOT))
        else $error("live count above slot count");

    a_hint_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_hint) <= 32'(NSLOT))
        else $error("free hint beyond table");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_s_tready)
        else $error("request taken while previous one in flight");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_fsm) == pstrq_pkg::S_DONE)
        else $error("result raised outside final step");

endmodule

// ===== rtl/pstrq_table.sv =====
// ----------------------------------------------------------------------------
// pstrq_table: slot table storage
// State/generation, next link and prev link memories; one shared read address,
// an independent write port per memory, registered read data.
// ----------------------------------------------------------------------------
module pstrq_table #(
    parameter int SW = 6,
    parameter int GW = 8
) (
    input  logic              i_clk,
    input  pstrq_pkg::t_tbl_we i_we,
    input  logic [SW-1:0]     i_sg_waddr,
    input  logic [GW+2:0]     i_sg_wdata,
    input  logic [SW-1:0]     i_nx_waddr,
    input  logic [SW:0]       i_nx_wdata,
    input  logic [SW-1:0]     i_pv_waddr,
    input  logic [SW:0]       i_pv_wdata,
    input  logic [SW-1:0]     i_raddr,
    output logic [GW+2:0]     o_sg_rdata,
    output logic [SW:0]       o_nx_rdata,
    output logic [SW:0]       o_pv_rdata
);

    localparam int DEPTH = 1 << SW;

    logic [GW+2:0] mem_sg [DEPTH];
    logic [SW:0]   mem_nx [DEPTH];
    logic [SW:0]   mem_pv [DEPTH];

    logic [GW+2:0] r_sg_rdata;
    logic [SW:0]   r_nx_rdata;
    logic [SW:0]   r_pv_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we.sg) begin
            mem_sg[i_sg_waddr] <= i_sg_wdata;
        end
        if (i_we.nx) begin
            mem_nx[i_nx_waddr] <= i_nx_wdata;
        end
        if (i_we.pv) begin
            mem_pv[i_pv_waddr] <= i_pv_wdata;
        end
        r_sg_rdata <= mem_sg[i_raddr];
        r_nx_rdata <= mem_nx[i_raddr];
        r_pv_rdata <= mem_pv[i_raddr];
    end

    assign o_sg_rdata = r_sg_rdata;
    assign o_nx_rdata = r_nx_rdata;
    assign o_pv_rdata = r_pv_rdata;

endmodule

// ===== bench/process_slot_table_run_queue_top_tb.sv =====
// ----------------------------------------------------------------------------
// process_slot_table_run_queue_top_tb: self-checking bench for the slot table
// Drives scheduler requests on the s-side stream, predicts each result from a
// shadow slot table and run queue, and checks every result on the m-side
// stream field by field. Several max_live settings, slot retirement at
// GEN_MAX, table exhaustion, and random traffic with stalls on both sides.
// ----------------------------------------------------------------------------
module process_slot_table_run_queue_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          NSLOT      = 64;
    localparam int          GEN_MAX    = 255;
    localparam int          LINK_NONE  = -1;
    localparam int          WDOG_LIMIT = 3000;
    localparam logic [3:0]  ACT_UNKNOWN_LO = 4'd9;
    localparam logic [3:0]  ACT_UNKNOWN_HI = 4'd15;

    // how a queued request picks its pid when it is presented
    localparam int PK_NONE     = 0;
    localparam int PK_LIVE     = 1;
    localparam int PK_RUNNING  = 2;
    localparam int PK_WAITING  = 3;
    localparam int PK_RUNNABLE = 4;
    localparam int PK_NEWEST   = 5;

    typedef struct {
        logic [3:0] action;
        logic [5:0] slot;
        logic [7:0] gen;
        int         pick;
    } t_sched_req;

    typedef struct {
        logic [1:0] status;
        logic [5:0] slot;
        logic [7:0] gen;
        logic       flag;
    } t_sched_rsp;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [6:0]  i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;    // action[3:0], pid_slot[9:4], pid_generation[17:10]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;    // status[1:0], out_slot[7:2], out_generation[15:8], flag[16]

    process_slot_table_run_queue_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // shadow slot table
    logic [2:0] tbl_state [NSLOT];
    int         tbl_gen   [NSLOT];
    int         tbl_next  [NSLOT];
    int         tbl_prev  [NSLOT];
    int         rq_head, rq_tail, rq_count, live_count, free_hint, max_live;
    int         newest_slot;

    t_sched_req pending_reqs[$];
    t_sched_rsp expected_rsps[$];
    t_sched_req cur_req;
    int         presented_n, accepted_n, errors, quiet_cycles;
    bit         no_idle;

    always #5 i_clk = ~i_clk;

    function automatic bool_live(input int s);
        return tbl_state[s] == pstrq_pkg::ST_RUNNABLE ||
               tbl_state[s] == pstrq_pkg::ST_RUNNING ||
               tbl_state[s] == pstrq_pkg::ST_WAITING;
    endfunction

    function automatic bit pid_valid(input int s, input int g);
        return tbl_gen[s] == g && bool_live(s);
    endfunction

    function automatic void rq_append(input int s);
        tbl_next[s] = LINK_NONE;
        tbl_prev[s] = rq_tail;
        if (rq_tail == LINK_NONE) rq_head = s;
        else tbl_next[rq_tail] = s;
        rq_tail = s;
        rq_count++;
    endfunction

    function automatic void rq_unlink(input int s);
        int nx, pv;
        nx = tbl_next[s];
        pv = tbl_prev[s];
        if (pv == LINK_NONE) rq_head = nx;
        else tbl_next[pv] = nx;
        if (nx == LINK_NONE) rq_tail = pv;
        else tbl_prev[nx] = pv;
        tbl_next[s] = LINK_NONE;
        tbl_prev[s] = LINK_NONE;
        if (rq_count > 0) rq_count--;
    endfunction

    function automatic void table_clear();
        for (int i = 0; i < NSLOT; i++) begin
            tbl_state[i] = pstrq_pkg::ST_FREE;
            tbl_gen[i]   = 0;
            tbl_next[i]  = LINK_NONE;
            tbl_prev[i]  = LINK_NONE;
        end
        rq_head = LINK_NONE;
        rq_tail = LINK_NONE;
        rq_count = 0;
        live_count = 0;
        free_hint = 0;
        max_live = int'(pstrq_pkg::MAX_LIVE_RST);
        newest_slot = 0;
    endfunction

    // apply one request to the shadow table and return its result
    function automatic t_sched_rsp sched_apply(input t_sched_req r);
        t_sched_rsp o;
        int s, g, k, ng;
        s = int'(r.slot);
        g = int'(r.gen);
        o = '{pstrq_pkg::RS_OK, 6'd0, 8'd0, 1'b0};
        case (r.action)
            pstrq_pkg::ACT_SPAWN: begin
                if (live_count >= max_live) begin
                    o.status = pstrq_pkg::RS_LIMIT;
                end else begin
                    for (k = free_hint; k < NSLOT; k++) begin
                        if (tbl_state[k] == pstrq_pkg::ST_EXITED && tbl_gen[k] == GEN_MAX) begin
                            tbl_state[k] = pstrq_pkg::ST_RETIRED;
                            continue;
                        end
                        if (tbl_state[k] == pstrq_pkg::ST_FREE ||
                            tbl_state[k] == pstrq_pkg::ST_EXITED) break;
                    end
                    if (k >= NSLOT) begin
                        o.status = pstrq_pkg::RS_LIMIT;
                    end else begin
                        free_hint = k + 1;
                        ng = tbl_gen[k] + 1;
                        if (ng > GEN_MAX) ng = 1;
                        tbl_gen[k] = ng;
                        tbl_state[k] = pstrq_pkg::ST_RUNNABLE;
                        rq_append(k);
                        live_count++;
                        newest_slot = k;
                        o.slot = k[5:0];
                        o.gen = ng[7:0];
                    end
                end
            end
            pstrq_pkg::ACT_DISPATCH: begin
                if (!pid_valid(s, g)) o.status = pstrq_pkg::RS_BADPID;
                else if (tbl_state[s] != pstrq_pkg::ST_RUNNABLE)
                    o.status = pstrq_pkg::RS_BADSTATE;
                else begin
                    rq_unlink(s);
                    tbl_state[s] = pstrq_pkg::ST_RUNNING;
                end
            end
            pstrq_pkg::ACT_YIELD, pstrq_pkg::ACT_WAIT: begin
                if (!pid_valid(s, g)) o.status = pstrq_pkg::RS_BADPID;
                else if (tbl_state[s] != pstrq_pkg::ST_RUNNING)
                    o.status = pstrq_pkg::RS_BADSTATE;
                else if (r.action == pstrq_pkg::ACT_YIELD) begin
                    tbl_state[s] = pstrq_pkg::ST_RUNNABLE;
                    rq_append(s);
                end else begin
                    tbl_state[s] = pstrq_pkg::ST_WAITING;
                end
            end
            pstrq_pkg::ACT_WAKE: begin
                if (tbl_state[s] != pstrq_pkg::ST_WAITING) o.status = pstrq_pkg::RS_BADSTATE;
                else begin
                    tbl_state[s] = pstrq_pkg::ST_RUNNABLE;
                    rq_append(s);
                end
            end
            pstrq_pkg::ACT_REQUEUE: begin
                if (tbl_state[s] != pstrq_pkg::ST_RUNNABLE) o.status = pstrq_pkg::RS_BADSTATE;
                else begin
                    rq_unlink(s);
                    rq_append(s);
                end
            end
            pstrq_pkg::ACT_EXIT: begin
                if (pid_valid(s, g)) begin
                    if (tbl_state[s] == pstrq_pkg::ST_RUNNABLE) rq_unlink(s);
                    tbl_state[s] = pstrq_pkg::ST_EXITED;
                    if (s < free_hint) free_hint = s;
                    if (live_count > 0) live_count--;
                    o.flag = 1'b1;
                end
            end
            pstrq_pkg::ACT_ALIVE: o.flag = pid_valid(s, g);
            pstrq_pkg::ACT_RUNHEAD: begin
                if (rq_head != LINK_NONE) begin
                    o.slot = rq_head[5:0];
                    o.flag = 1'b1;
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    // fill in slot and generation from the current shadow table
    function automatic t_sched_req pid_resolve(input t_sched_req r);
        int start, s;
        bit hit;
        if (r.pick == PK_NEWEST) begin
            r.slot = newest_slot[5:0];
            r.gen = tbl_gen[newest_slot][7:0];
        end else if (r.pick != PK_NONE) begin
            start = $urandom_range(0, NSLOT - 1);
            for (int i = 0; i < NSLOT; i++) begin
                s = (start + i) % NSLOT;
                case (r.pick)
                    PK_LIVE:     hit = bool_live(s);
                    PK_RUNNING:  hit = tbl_state[s] == pstrq_pkg::ST_RUNNING;
                    PK_WAITING:  hit = tbl_state[s] == pstrq_pkg::ST_WAITING;
                    default:     hit = tbl_state[s] == pstrq_pkg::ST_RUNNABLE;
                endcase
                if (hit) begin
                    r.slot = s[5:0];
                    r.gen = tbl_gen[s][7:0];
                    break;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    task automatic push_req(input logic [3:0] act, input int pick,
                            input logic [5:0] s = 6'd0, input logic [7:0] g = 8'd0);
        pending_reqs.push_back('{act, s, g, pick});
    endtask

    task automatic push_random(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 20)      push_req(pstrq_pkg::ACT_SPAWN, PK_NONE);
            else if (r < 35) push_req(pstrq_pkg::ACT_DISPATCH, PK_RUNNABLE);
            else if (r < 47) push_req(pstrq_pkg::ACT_YIELD, PK_RUNNING);
            else if (r < 57) push_req(pstrq_pkg::ACT_WAIT, PK_RUNNING);
            else if (r < 67) push_req(pstrq_pkg::ACT_WAKE, PK_WAITING);
            else if (r < 74) push_req(pstrq_pkg::ACT_REQUEUE, PK_RUNNABLE);
            else if (r < 84) push_req(pstrq_pkg::ACT_EXIT, PK_LIVE);
            else if (r < 89) push_req(pstrq_pkg::ACT_ALIVE, PK_LIVE);
            else if (r < 93) push_req(pstrq_pkg::ACT_RUNHEAD, PK_NONE);
            else             // noise: any action, any pid
                push_req(4'($urandom_range(0, 15)), PK_NONE,
                         6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || i_s_tvalid || expected_rsps.size() != 0)
            @(posedge i_clk);
        // settle before the next config write
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_max_live(input logic [6:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        max_live = int'(v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // accept side: predict at the handshake
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            expected_rsps.push_back(sched_apply(cur_req));
            accepted_n++;
        end
    end

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || presented_n == accepted_n) begin
            if (pending_reqs.size() != 0 && (no_idle || $urandom_range(0, 99) >= 28)) begin
                cur_req = pid_resolve(pending_reqs.pop_front());
                i_s_tdata <= {6'd0, cur_req.gen, cur_req.slot, cur_req.action};
                i_s_tvalid <= 1'b1;
                presented_n++;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        i_m_tready <= no_idle || $urandom_range(0, 99) >= 28;
    end

    // result checker
    always @(posedge i_clk) begin
        t_sched_rsp want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_rsps.size() == 0) begin
                report_mismatch("results outstanding", 0, 1);
            end else begin
                want = expected_rsps.pop_front();
                if (o_m_tdata[1:0] != want.status)
                    report_mismatch("status", int'(o_m_tdata[1:0]), int'(want.status));
                if (o_m_tdata[7:2] != want.slot)
                    report_mismatch("out_slot", int'(o_m_tdata[7:2]), int'(want.slot));
                if (o_m_tdata[15:8] != want.gen)
                    report_mismatch("out_generation", int'(o_m_tdata[15:8]), int'(want.gen));
                if (o_m_tdata[16] != want.flag)
                    report_mismatch("flag", int'(o_m_tdata[16]), int'(want.flag));
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WDOG_LIMIT) begin
            $display("process_slot_table_run_queue_top_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 7'd0;
        i_s_tvalid = 1'b0;
        i_s_tdata = 24'd0;
        i_m_tready = 1'b0;
        presented_n = 0;
        accepted_n = 0;
        errors = 0;
        quiet_cycles = 0;
        no_idle = 1'b0;
        table_clear();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty queue, unknown action, bad pids, every operation
        push_req(pstrq_pkg::ACT_RUNHEAD, PK_NONE);
        push_req(ACT_UNKNOWN_HI, PK_NONE, 6'h3f, 8'hff);
        push_req(ACT_UNKNOWN_LO, PK_NONE, 6'h2a, 8'h55);
        push_req(pstrq_pkg::ACT_ALIVE, PK_NONE, 6'h3f, 8'hff);
        push_req(pstrq_pkg::ACT_DISPATCH, PK_NONE, 6'd0, 8'd0);
        push_req(pstrq_pkg::ACT_WAKE, PK_NONE, 6'd5, 8'd0);
        push_req(pstrq_pkg::ACT_REQUEUE, PK_NONE, 6'd0, 8'd0);
        push_req(pstrq_pkg::ACT_EXIT, PK_NONE, 6'd0, 8'd1);
        repeat (3) push_req(pstrq_pkg::ACT_SPAWN, PK_NONE);
        push_req(pstrq_pkg::ACT_RUNHEAD, PK_NONE);
        push_req(pstrq_pkg::ACT_DISPATCH, PK_RUNNABLE);
        push_req(pstrq_pkg::ACT_DISPATCH, PK_RUNNING);
        push_req(pstrq_pkg::ACT_YIELD, PK_RUNNING);
        push_req(pstrq_pkg::ACT_DISPATCH, PK_RUNNABLE);
        push_req(pstrq_pkg::ACT_WAIT, PK_RUNNING);
        push_req(pstrq_pkg::ACT_WAKE, PK_WAITING);
        push_req(pstrq_pkg::ACT_YIELD, PK_RUNNABLE);
        push_req(pstrq_pkg::ACT_REQUEUE, PK_RUNNABLE);
        push_req(pstrq_pkg::ACT_ALIVE, PK_LIVE);
        push_req(pstrq_pkg::ACT_EXIT, PK_LIVE);
        push_req(pstrq_pkg::ACT_EXIT, PK_NEWEST);
        push_req(pstrq_pkg::ACT_ALIVE, PK_NEWEST);
        push_req(pstrq_pkg::ACT_SPAWN, PK_NONE);
        wait_drained();

        // one live process at most
        write_max_live(7'd1);
        push_random(30);
        wait_drained();

        // spawn always refused
        write_max_live(7'd0);
        repeat (3) push_req(pstrq_pkg::ACT_SPAWN, PK_NONE);
        push_req(pstrq_pkg::ACT_RUNHEAD, PK_NONE);
        wait_drained();

        // drain the table, then churn one slot until it is retired at GEN_MAX
        write_max_live(7'h7f);
        no_idle = 1'b1;
        repeat (66) push_req(pstrq_pkg::ACT_EXIT, PK_LIVE);
        for (int i = 0; i < 258; i++) begin
            if (i == 100) begin
                while (pending_reqs.size() > 40) @(posedge i_clk);
                no_idle = 1'b0;
            end
            push_req(pstrq_pkg::ACT_SPAWN, PK_NONE);
            push_req(pstrq_pkg::ACT_EXIT, PK_NEWEST);
        end
        wait_drained();

        // fill the table past its last usable slot, then mix
        write_max_live(pstrq_pkg::MAX_LIVE_RST);
        repeat (70) push_req(pstrq_pkg::ACT_SPAWN, PK_NONE);
        push_random(80);
        wait_drained();

        write_max_live(7'd40);
        push_random(50);
        wait_drained();

        if (errors == 0)
            $display("process_slot_table_run_queue_top_tb: PASS");
        else
            $display("process_slot_table_run_queue_top_tb: FAIL");
        $finish;
    end

endmodule
